[hw/rtl/rpn_pkg.sv]
// Shared types and codes of the fraction stack calculator.
package rpn_pkg;

    typedef enum logic [3:0] {
        OP_LIT     = 4'd0,
        OP_DUP     = 4'd1,
        OP_SWAP    = 4'd2,
        OP_DROP    = 4'd3,
        OP_CLEAR   = 4'd4,
        OP_ADD     = 4'd5,
        OP_SUB     = 4'd6,
        OP_MUL     = 4'd7,
        OP_DIV     = 4'd8,
        OP_UNKNOWN = 4'd9,
        OP_QUIT    = 4'd10
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ERROR   = 2'd1,
        ST_QUIT    = 2'd2,
        ST_HALTED  = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_PUSH_LIT,
        DP_WRITE_RD,
        DP_CAP_A,
        DP_CAP_B,
        DP_WRITE_A,
        DP_WRITE_B,
        DP_MUL0,
        DP_MUL1,
        DP_MUL2,
        DP_WRITE_RES,
        DP_CAP_TOP,
        DP_DIV_GCD,
        DP_GCD_STEP,
        DP_DIV_N,
        DP_CAP_QN,
        DP_DIV_D,
        DP_CAP_QD,
        DP_EMIT_EMPTY,
        DP_EMIT_TOP
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        opcode_t opcode;
        status_t emit_status;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic d_zero;
        logic y_zero;
        logic out_full;
    } dp_stat_t;

endpackage

[hw/rtl/rpn_div.sv]
// Unsigned 32-bit restoring divider, one quotient bit per cycle.
module rpn_div
    import rpn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [31:0] remainder
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic [31:0] dvs_reg;
    logic [63:0] shifted;

    always_comb
    begin
        shifted = {acc_reg[62:0], 1'b0};
        if (shifted[63:32] >= dvs_reg)
        begin
            acc_next = {shifted[63:32] - dvs_reg, shifted[31:1], 1'b1};
        end
        else
        begin
            acc_next = shifted;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= {32'd0, dividend};
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = acc_reg[31:0];
    assign remainder = acc_reg[63:32];

endmodule

[hw/rtl/rpn_dp.sv]
// Datapath: fraction stack memory, shared multiplier, GCD reduction and result register.
module rpn_dp
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = 32,
    parameter int AW = $clog2(STACK_DEPTH)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    input  logic [AW-1:0]      rd_addr,
    input  logic [AW-1:0]      wr_addr,
    input  logic [30:0]        literal_value,
    input  logic               out_stall,
    output dp_stat_t           stat,
    output logic               out_valid,
    output logic [1:0]         status,
    output logic               top_valid,
    output logic signed [31:0] top_numerator,
    output logic signed [31:0] top_denominator
);

    logic [63:0] mem [STACK_DEPTH];
    logic [63:0] rdata_reg;
    logic [63:0] wdata;
    logic        we;

    logic [30:0] lit_reg;
    logic [31:0] a_num_reg, a_den_reg, b_num_reg, b_den_reg;
    logic [31:0] p0_reg, p1_reg, p2_reg;
    logic [31:0] n_reg, d_reg, x_reg, y_reg, fn_reg, fd_reg;
    logic        par_reg;

    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic        top_valid_reg;
    logic [31:0] num_out_reg, den_out_reg;

    logic [31:0] mul_a, mul_b, mul_lo, res_num;
    logic [31:0] abs_n, abs_d, abs_top_n, abs_top_d;
    logic [31:0] div_dividend, div_divisor, div_q, div_r;
    logic        div_start, div_done, g_sign;

    assign abs_top_n = rdata_reg[63] ? 32'd0 - rdata_reg[63:32] : rdata_reg[63:32];
    assign abs_top_d = rdata_reg[31] ? 32'd0 - rdata_reg[31:0] : rdata_reg[31:0];
    assign abs_n     = n_reg[31] ? 32'd0 - n_reg : n_reg;
    assign abs_d     = d_reg[31] ? 32'd0 - d_reg : d_reg;
    // The GCD takes the sign of n or d depending on the parity of the last Euclid term.
    assign g_sign    = par_reg ? d_reg[31] : n_reg[31];

    // Operand selection for the three products of one arithmetic token.
    always_comb
    begin
        mul_a = a_num_reg;
        mul_b = b_den_reg;
        unique case (cmd.op)
            DP_MUL0:
            begin
                priority case (cmd.opcode)
                    OP_SUB:
                    begin
                        mul_a = b_num_reg;
                        mul_b = a_den_reg;
                    end
                    OP_MUL:
                    begin
                        mul_a = a_num_reg;
                        mul_b = b_num_reg;
                    end
                    OP_DIV:
                    begin
                        mul_a = a_den_reg;
                        mul_b = b_num_reg;
                    end
                    default:
                    begin
                        mul_a = a_num_reg;
                        mul_b = b_den_reg;
                    end
                endcase
            end
            DP_MUL1:
            begin
                if (cmd.opcode == OP_ADD)
                begin
                    mul_a = b_num_reg;
                    mul_b = a_den_reg;
                end
            end
            DP_MUL2:
            begin
                if (cmd.opcode != OP_DIV)
                begin
                    mul_a = a_den_reg;
                end
            end
            default:
            begin
                mul_a = a_num_reg;
            end
        endcase
    end

    assign mul_lo = mul_a * mul_b;

    always_comb
    begin
        priority case (cmd.opcode)
            OP_ADD:  res_num = p0_reg + p1_reg;
            OP_SUB:  res_num = p0_reg - p1_reg;
            default: res_num = p0_reg;
        endcase
    end

    always_comb
    begin
        we    = 1'b1;
        wdata = rdata_reg;
        unique case (cmd.op)
            DP_PUSH_LIT:  wdata = {1'b0, lit_reg, 32'd1};
            DP_WRITE_RD:  wdata = rdata_reg;
            DP_WRITE_A:   wdata = {a_num_reg, a_den_reg};
            DP_WRITE_B:   wdata = {b_num_reg, b_den_reg};
            DP_WRITE_RES: wdata = {res_num, p2_reg};
            default:      we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wdata;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_comb
    begin
        div_start    = 1'b1;
        div_dividend = x_reg;
        div_divisor  = x_reg;
        unique case (cmd.op)
            DP_DIV_GCD:
            begin
                div_dividend = x_reg;
                div_divisor  = y_reg;
            end
            DP_DIV_N: div_dividend = abs_n;
            DP_DIV_D: div_dividend = abs_d;
            default:  div_start = 1'b0;
        endcase
    end

    rpn_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            DP_LOAD:     lit_reg <= literal_value;
            DP_CAP_A:
            begin
                a_num_reg <= rdata_reg[63:32];
                a_den_reg <= rdata_reg[31:0];
            end
            DP_CAP_B:
            begin
                b_num_reg <= rdata_reg[63:32];
                b_den_reg <= rdata_reg[31:0];
            end
            DP_MUL0:     p0_reg <= mul_lo;
            DP_MUL1:     p1_reg <= mul_lo;
            DP_MUL2:     p2_reg <= mul_lo;
            DP_CAP_TOP:
            begin
                n_reg  <= rdata_reg[63:32];
                d_reg  <= rdata_reg[31:0];
                fn_reg <= rdata_reg[63:32];
                fd_reg <= rdata_reg[31:0];
                x_reg  <= abs_top_n;
                y_reg  <= abs_top_d;
                par_reg <= 1'b0;
            end
            DP_GCD_STEP:
            begin
                x_reg   <= y_reg;
                y_reg   <= div_r;
                par_reg <= ~par_reg;
            end
            DP_CAP_QN:   fn_reg <= (n_reg[31] ^ g_sign) ? 32'd0 - div_q : div_q;
            DP_CAP_QD:   fd_reg <= (d_reg[31] ^ g_sign) ? 32'd0 - div_q : div_q;
            default:
            begin
                lit_reg <= lit_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == DP_EMIT_EMPTY || cmd.op == DP_EMIT_TOP)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_EMIT_EMPTY)
        begin
            status_reg    <= cmd.emit_status;
            top_valid_reg <= 1'b0;
            num_out_reg   <= 32'd0;
            den_out_reg   <= 32'd0;
        end
        else if (cmd.op == DP_EMIT_TOP)
        begin
            status_reg    <= ST_OK;
            top_valid_reg <= 1'b1;
            num_out_reg   <= fn_reg;
            den_out_reg   <= fd_reg;
        end
    end

    assign stat.div_done = div_done;
    assign stat.d_zero   = (d_reg == 32'd0);
    assign stat.y_zero   = (y_reg == 32'd0);
    assign stat.out_full = out_valid_reg;

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign top_valid       = top_valid_reg;
    assign top_numerator   = num_out_reg;
    assign top_denominator = den_out_reg;

endmodule

[hw/rtl/rpn_ctrl.sv]
// Controller: token decode, stack pointer, halt flag and sequencing of the datapath.
module rpn_ctrl
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = 32,
    parameter int AW = $clog2(STACK_DEPTH)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [3:0]    opcode,
    input  dp_stat_t      stat,
    output dp_cmd_t       cmd,
    output logic [AW-1:0] rd_addr,
    output logic [AW-1:0] wr_addr
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_DUP_W, S_RD_B, S_CAP_B, S_SWAP1, S_SWAP2,
        S_MUL0, S_MUL1, S_MUL2, S_WRES, S_TOP, S_CAP_TOP, S_CHK_D,
        S_G_START, S_G_WAIT, S_G_CHECK, S_N_START, S_N_WAIT, S_D_START,
        S_D_WAIT, S_EMIT_EMPTY, S_EMIT_TOP
    } state_t;

    state_t         state_reg, state_next;
    opcode_t        op_reg, op_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           halted_reg, halted_next;
    status_t        emit_reg, emit_next;
    logic [CW-1:0]  cnt_m1, cnt_m2;
    logic [AW-1:0]  top_addr, sec_addr, cnt_addr;

    assign cnt_m1   = count_reg - CW'(1);
    assign cnt_m2   = count_reg - CW'(2);
    assign top_addr = cnt_m1[AW-1:0];
    assign sec_addr = cnt_m2[AW-1:0];
    assign cnt_addr = count_reg[AW-1:0];

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        count_next      = count_reg;
        halted_next     = halted_reg;
        emit_next       = emit_reg;
        cmd.op          = DP_NOP;
        cmd.opcode      = op_reg;
        cmd.emit_status = emit_reg;
        rd_addr         = top_addr;
        wr_addr         = cnt_addr;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = opcode_t'(opcode);
                    cmd.op     = DP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (halted_reg)
                begin
                    emit_next  = ST_HALTED;
                    state_next = S_EMIT_EMPTY;
                end
                else
                begin
                    unique case (op_reg)
                        OP_LIT:
                        begin
                            if (count_reg == DEPTH_C)
                            begin
                                emit_next   = ST_ERROR;
                                halted_next = 1'b1;
                                state_next  = S_EMIT_EMPTY;
                            end
                            else
                            begin
                                cmd.op     = DP_PUSH_LIT;
                                count_next = count_reg + CW'(1);
                                state_next = S_TOP;
                            end
                        end
                        OP_DUP:
                        begin
                            if (count_reg == '0 || count_reg == DEPTH_C)
                            begin
                                emit_next   = ST_ERROR;
                                halted_next = 1'b1;
                                state_next  = S_EMIT_EMPTY;
                            end
                            else
                            begin
                                state_next = S_DUP_W;
                            end
                        end
                        OP_DROP:
                        begin
                            if (count_reg != '0)
                            begin
                                count_next = cnt_m1;
                            end
                            state_next = S_TOP;
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_TOP;
                        end
                        OP_QUIT:
                        begin
                            emit_next   = ST_QUIT;
                            halted_next = 1'b1;
                            state_next  = S_EMIT_EMPTY;
                        end
                        default:
                        begin
                            // Swap, the arithmetic operators and any unknown code.
                            if (count_reg < CW'(2))
                            begin
                                emit_next   = ST_ERROR;
                                halted_next = 1'b1;
                                state_next  = S_EMIT_EMPTY;
                            end
                            else
                            begin
                                state_next = S_RD_B;
                            end
                        end
                    endcase
                end
            end
            S_DUP_W:
            begin
                cmd.op     = DP_WRITE_RD;
                count_next = count_reg + CW'(1);
                state_next = S_TOP;
            end
            S_RD_B:
            begin
                cmd.op     = DP_CAP_A;
                rd_addr    = sec_addr;
                state_next = S_CAP_B;
            end
            S_CAP_B:
            begin
                cmd.op = DP_CAP_B;
                if (op_reg == OP_SWAP)
                begin
                    state_next = S_SWAP1;
                end
                else
                begin
                    count_next = cnt_m2;
                    if (op_reg == OP_ADD || op_reg == OP_SUB || op_reg == OP_MUL ||
                        op_reg == OP_DIV)
                    begin
                        state_next = S_MUL0;
                    end
                    else
                    begin
                        state_next = S_TOP;
                    end
                end
            end
            S_SWAP1:
            begin
                cmd.op     = DP_WRITE_A;
                wr_addr    = sec_addr;
                state_next = S_SWAP2;
            end
            S_SWAP2:
            begin
                cmd.op     = DP_WRITE_B;
                wr_addr    = top_addr;
                state_next = S_TOP;
            end
            S_MUL0:
            begin
                cmd.op     = DP_MUL0;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.op     = DP_MUL1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.op     = DP_MUL2;
                state_next = S_WRES;
            end
            S_WRES:
            begin
                cmd.op     = DP_WRITE_RES;
                count_next = count_reg + CW'(1);
                state_next = S_TOP;
            end
            S_TOP:
            begin
                if (count_reg == '0)
                begin
                    emit_next  = ST_OK;
                    state_next = S_EMIT_EMPTY;
                end
                else
                begin
                    state_next = S_CAP_TOP;
                end
            end
            S_CAP_TOP:
            begin
                cmd.op     = DP_CAP_TOP;
                state_next = S_CHK_D;
            end
            S_CHK_D:
            begin
                state_next = stat.d_zero ? S_EMIT_TOP : S_G_START;
            end
            S_G_START:
            begin
                cmd.op     = DP_DIV_GCD;
                state_next = S_G_WAIT;
            end
            S_G_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = DP_GCD_STEP;
                    state_next = S_G_CHECK;
                end
            end
            S_G_CHECK:
            begin
                state_next = stat.y_zero ? S_N_START : S_G_START;
            end
            S_N_START:
            begin
                cmd.op     = DP_DIV_N;
                state_next = S_N_WAIT;
            end
            S_N_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = DP_CAP_QN;
                    state_next = S_D_START;
                end
            end
            S_D_START:
            begin
                cmd.op     = DP_DIV_D;
                state_next = S_D_WAIT;
            end
            S_D_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = DP_CAP_QD;
                    state_next = S_EMIT_TOP;
                end
            end
            S_EMIT_EMPTY:
            begin
                if (!stat.out_full)
                begin
                    cmd.op     = DP_EMIT_EMPTY;
                    state_next = S_IDLE;
                end
            end
            S_EMIT_TOP:
            begin
                if (!stat.out_full)
                begin
                    cmd.op     = DP_EMIT_TOP;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            op_reg     <= OP_LIT;
            count_reg  <= '0;
            halted_reg <= 1'b0;
            emit_reg   <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            count_reg  <= count_next;
            halted_reg <= halted_next;
            emit_reg   <= emit_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

[hw/rtl/rpn_rational_stack_calculator.sv]
// Top level of the fraction stack calculator: controller, datapath and checks.
//
// Input channel: in_valid, in_stall, opcode, literal_value; one decoded token per item.
// Output channel: out_valid, out_stall, status, top_valid, top_numerator,
// top_denominator; exactly one result item per token.
// One token is processed at a time; in_stall is high from acceptance until the
// result has been loaded into the output register, so the next token may be
// taken while that result still waits for the receiver.
// An ignored, erroneous or quit token goes from decode straight to the result.
// Otherwise the stack is updated first; arithmetic forms its three products on one
// shared multiplier. An empty stack then reports with no top; otherwise the top is
// read, and a zero denominator is reported as stored. Reduction uses a divider that
// retires one bit per cycle: one division per Euclid remainder step (1 to about 46
// steps), then two for the final quotients of numerator and denominator. The next
// token can be taken in the cycle after the result is loaded.
// Reset clears the stack count, the halt flag and the output valid flag; stack
// contents are not cleared and need no clearing pass.
// When the receiver stalls, the result item holds and the block waits before
// writing its next result.
module rpn_rational_stack_calculator
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [3:0]         opcode,
    input  logic [30:0]        literal_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic               top_valid,
    output logic signed [31:0] top_numerator,
    output logic signed [31:0] top_denominator
);

    localparam int AW = $clog2(STACK_DEPTH);

    dp_cmd_t       cmd;
    dp_stat_t      stat;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    rpn_ctrl #(
        .STACK_DEPTH (STACK_DEPTH),
        .AW          (AW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .opcode   (opcode),
        .stat     (stat),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr)
    );

    rpn_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .AW          (AW)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .rd_addr         (rd_addr),
        .wr_addr         (wr_addr),
        .literal_value   (literal_value),
        .out_stall       (out_stall),
        .stat            (stat),
        .out_valid       (out_valid),
        .status          (status),
        .top_valid       (top_valid),
        .top_numerator   (top_numerator),
        .top_denominator (top_denominator)
    );

    // An error, quit or ignored token never reports a fraction.
    a_no_top_on_halt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> !top_valid)
        else $error("fraction reported with a non-ok status");

    a_zero_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !top_valid |-> top_numerator == 32'sd0 && top_denominator == 32'sd0)
        else $error("fraction fields not zero without a top entry");

    // Tokens are handled one at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second token taken while one is in flight");

endmodule

[bench/rpn_fraction_checker.sv]
// Checker for the fraction stack calculator: predicts each result and compares.
module rpn_fraction_checker
    import rpn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [3:0]  opcode,
    input  logic [30:0] literal_value,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  status,
    input  logic        top_valid,
    input  logic [31:0] top_numerator,
    input  logic [31:0] top_denominator,
    output int          fail_count,
    output int          pending
);

    localparam int DEPTH = 32;

    typedef struct {
        status_t     st;
        logic        tv;
        logic [31:0] num;
        logic [31:0] den;
    } top_report_t;

    logic [31:0]  frac_num [DEPTH];
    logic [31:0]  frac_den [DEPTH];
    int           depth_now = 0;
    bit           stopped = 0;
    top_report_t  report_queue [$];

    assign pending = report_queue.size();

    function automatic logic [31:0] signed_gcd(logic [31:0] x, logic [31:0] y);
        longint a;
        longint b;
        longint t;
        a = longint'($signed(x));
        b = longint'($signed(y));
        while (b != 0)
        begin
            t = b;
            b = a % b;
            a = t;
        end
        return a[31:0];
    endfunction

    function automatic logic [31:0] quot_trunc(logic [31:0] x, logic [31:0] y);
        longint q;
        q = longint'($signed(x)) / longint'($signed(y));
        return q[31:0];
    endfunction

    task automatic push_frac(logic [31:0] n, logic [31:0] d);
        frac_num[depth_now] = n;
        frac_den[depth_now] = d;
        depth_now++;
    endtask

    task automatic apply_token(logic [3:0] op, logic [30:0] lit);
        top_report_t r;
        logic [31:0] tn, td, sn, sd, g;
        r.st = ST_OK;
        r.tv = 1'b0;
        r.num = '0;
        r.den = '0;
        if (stopped)
        begin
            r.st = ST_HALTED;
        end
        else
        begin
            case (op)
                OP_LIT:
                    if (depth_now >= DEPTH) r.st = ST_ERROR;
                    else push_frac({1'b0, lit}, 32'd1);
                OP_DUP:
                    if (depth_now == 0 || depth_now >= DEPTH) r.st = ST_ERROR;
                    else push_frac(frac_num[depth_now-1], frac_den[depth_now-1]);
                OP_DROP:
                    if (depth_now > 0) depth_now--;
                OP_CLEAR:
                    depth_now = 0;
                OP_QUIT:
                    r.st = ST_QUIT;
                default:
                    if (depth_now < 2)
                    begin
                        r.st = ST_ERROR;
                    end
                    else
                    begin
                        tn = frac_num[depth_now-1];
                        td = frac_den[depth_now-1];
                        sn = frac_num[depth_now-2];
                        sd = frac_den[depth_now-2];
                        depth_now -= 2;
                        case (op)
                            OP_SWAP:
                            begin
                                push_frac(tn, td);
                                push_frac(sn, sd);
                            end
                            OP_ADD: push_frac(tn * sd + sn * td, td * sd);
                            OP_SUB: push_frac(sn * td - tn * sd, td * sd);
                            OP_MUL: push_frac(tn * sn, td * sd);
                            OP_DIV: push_frac(td * sn, tn * sd);
                            default: ;
                        endcase
                    end
            endcase
            if (r.st != ST_OK)
            begin
                stopped = 1;
            end
            else if (depth_now > 0)
            begin
                r.tv = 1'b1;
                r.num = frac_num[depth_now-1];
                r.den = frac_den[depth_now-1];
                // A zero denominator is reported as stored.
                if (r.den != 0)
                begin
                    g = signed_gcd(r.num, r.den);
                    r.num = quot_trunc(r.num, g);
                    r.den = quot_trunc(r.den, g);
                end
            end
        end
        report_queue.push_back(r);
    endtask

    initial fail_count = 0;

    always @(posedge clk)
    begin
        top_report_t e;
        if (rst_n)
        begin
            // Results are taken before new items so a same-edge pair stays in order.
            if (out_valid && !out_stall)
            begin
                if (report_queue.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result item with nothing expected: st=%0d tv=%0d %h/%h",
                                 status, top_valid, top_numerator, top_denominator);
                end
                else
                begin
                    e = report_queue.pop_front();
                    if (status !== e.st || top_valid !== e.tv ||
                        top_numerator !== e.num || top_denominator !== e.den)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected st=%0d tv=%0d %h/%h, got st=%0d tv=%0d %h/%h",
                                     e.st, e.tv, e.num, e.den, status, top_valid,
                                     top_numerator, top_denominator);
                    end
                end
            end
            if (in_valid && !in_stall)
                apply_token(opcode, literal_value);
        end
    end

endmodule

[bench/rpn_rational_stack_calculator_tb.sv]
// Testbench top of the fraction stack calculator: stimulus and verdict.
module rpn_rational_stack_calculator_tb;
    import rpn_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [3:0]  opcode = OP_LIT;
    logic [30:0] literal_value = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic        top_valid;
    logic signed [31:0] top_numerator;
    logic signed [31:0] top_denominator;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int depth_model = 0;
    bit hold_request = 0;
    bit hold_taken = 0;
    int hold_left = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    rpn_rational_stack_calculator DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .literal_value(literal_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .top_valid(top_valid),
        .top_numerator(top_numerator), .top_denominator(top_denominator)
    );

    rpn_fraction_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .literal_value(literal_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .top_valid(top_valid),
        .top_numerator(top_numerator), .top_denominator(top_denominator),
        .fail_count(fail_count), .pending(pending)
    );

    // Receiver: random stalls, plus one long hold-off that lets the block fill up.
    always @(posedge clk)
    begin
        if (hold_request && !hold_taken)
        begin
            hold_taken <= 1;
            hold_left <= 400;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic send_token(logic [3:0] op, logic [30:0] val);
        logic stall_seen;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        literal_value <= val;
        do
        begin
            @(negedge clk);
            stall_seen = in_stall;
            @(posedge clk);
        end
        while (stall_seen);
        case (op)
            OP_LIT, OP_DUP: depth_model++;
            OP_DROP: if (depth_model > 0) depth_model--;
            OP_CLEAR: depth_model = 0;
            OP_SWAP, OP_QUIT: ;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: depth_model--;
            default: depth_model -= 2;
        endcase
    endtask

    function automatic logic [30:0] pick_literal();
        case ($urandom_range(3))
            0: return 31'($urandom_range(9));
            1: return ($urandom_range(1)) ? 31'h7FFF_FFFF : 31'd1;
            default: return 31'($urandom);
        endcase
    endfunction

    // Only legal tokens here: a stack error or quit halts the block for good.
    task automatic send_random_token();
        logic [3:0] op;
        int roll;
        roll = $urandom_range(99);
        if (roll < 35) op = OP_LIT;
        else if (roll < 42) op = OP_DUP;
        else if (roll < 48) op = OP_SWAP;
        else if (roll < 53) op = OP_DROP;
        else if (roll < 55) op = OP_CLEAR;
        else if (roll < 65) op = OP_ADD;
        else if (roll < 75) op = OP_SUB;
        else if (roll < 85) op = OP_MUL;
        else if (roll < 95) op = OP_DIV;
        else op = 4'($urandom_range(OP_UNKNOWN, 15));
        if (op == OP_QUIT)
            op = OP_UNKNOWN;
        if ((op == OP_LIT || op == OP_DUP) && depth_model >= 32)
            op = OP_DROP;
        else if (op == OP_DUP && depth_model == 0)
            op = OP_LIT;
        else if (op != OP_LIT && op != OP_DUP && op != OP_DROP && op != OP_CLEAR &&
                 depth_model < 2)
            op = OP_LIT;
        send_token(op, (op == OP_LIT) ? pick_literal() : 31'($urandom));
    endtask

    initial
    begin
        #40_000_000;
        $display("rpn_rational_stack_calculator_tb NOT OK");
        $finish;
    end

    initial
    begin
        int kind;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, every operation but quit, zero denominator, full stack.
        send_token(OP_DROP, 31'd0);
        send_token(OP_LIT, 31'd0);
        send_token(OP_LIT, 31'h7FFF_FFFF);
        send_token(OP_DUP, 31'd0);
        send_token(OP_SWAP, 31'd0);
        send_token(OP_ADD, 31'd0);
        send_token(OP_LIT, 31'd3);
        send_token(OP_SUB, 31'd0);
        send_token(OP_LIT, 31'd2);
        send_token(OP_MUL, 31'd0);
        send_token(OP_LIT, 31'd6);
        send_token(OP_DIV, 31'd0);
        send_token(OP_LIT, 31'd0);
        send_token(OP_DIV, 31'd0);
        send_token(OP_LIT, 31'd5);
        send_token(OP_UNKNOWN, 31'h7FFF_FFFF);
        send_token(OP_LIT, 31'd1);
        send_token(4'd15, 31'd0);
        send_token(OP_CLEAR, 31'd0);
        while (depth_model < 32)
            send_token(OP_LIT, pick_literal());
        send_token(OP_CLEAR, 31'd0);

        // Random, with a long receiver hold-off early on.
        hold_request = 1;
        for (int i = 0; i < 500; i++)
        begin
            case ((i / 50) % 5)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                3: begin send_idle_pct = 32; recv_stall_pct = 32; end
                default: begin send_idle_pct = $urandom_range(50); recv_stall_pct = 0; end
            endcase
            send_random_token();
        end

        // One halting event, then a few tokens that must be ignored.
        kind = $urandom_range(2);
        if (kind == 0)
        begin
            send_token(OP_QUIT, 31'd0);
        end
        else if (kind == 1)
        begin
            send_token(OP_CLEAR, 31'd0);
            send_token(OP_ADD, 31'd0);
        end
        else
        begin
            while (depth_model < 32)
                send_token(OP_LIT, pick_literal());
            send_token(($urandom_range(1)) ? OP_LIT : OP_DUP, 31'h7FFF_FFFF);
        end
        repeat (3) send_token(4'($urandom_range(15)), 31'($urandom));
        in_valid <= 1'b0;

        wait (pending == 0);
        repeat (2000) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("rpn_rational_stack_calculator_tb OK");
        else
            $display("rpn_rational_stack_calculator_tb NOT OK");
        $finish;
    end

endmodule
